// ===== hw/rtl/smef_pkg.sv =====
package smef_pkg;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned WINDOW_LEN   = 11;

  localparam int unsigned CH_W   = 3;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned AGE_W  = 4;
  localparam int unsigned DIST_W = 16;

  localparam logic [TIME_W-1:0] RESET_TIME = 16'd29500;
  localparam logic [TIME_W:0]   TIME_OFFSET = 17'd500;

  // floor(x / 58) == (x * DIST_RECIP) >> DIST_SHIFT, exact for x < 2^20
  localparam int unsigned MAG_W      = 20;
  localparam int unsigned RECIP_W    = 21;
  localparam int unsigned PROD_W     = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1157050;
  localparam int unsigned DIST_SHIFT = 26;
  localparam int unsigned QUOT_W     = 15;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] echo_time;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel_out;
    logic signed [DIST_W-1:0] distance;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] value;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // Passed left to right along the cell row.
  typedef struct packed {
    logic   removed;  // oldest entry found at or left of this cell
    logic   placed;   // insert slot found at or left of this cell
    entry_t kept;     // this cell's entry after removal
  } link_t;

endpackage

// ===== hw/rtl/smef_cell.sv =====
module smef_cell #(
  parameter int unsigned CHANNELS = smef_pkg::NUM_CHANNELS,
  parameter int unsigned IDX_W = 3,
  parameter logic [smef_pkg::AGE_W-1:0] RESET_AGE = '0,
  parameter bit LAST = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [smef_pkg::TIME_W-1:0]  time_i,
  input  logic [smef_pkg::AGE_W-1:0]   oldest_i,
  input  logic [smef_pkg::AGE_W-1:0]   new_age_i,
  input  smef_pkg::link_t              link_i,
  input  smef_pkg::entry_t             right_i,
  output smef_pkg::link_t              link_o,
  output smef_pkg::entry_t             entry_o,
  output smef_pkg::entry_t             next_o
);
  import smef_pkg::*;

  logic [TIME_W-1:0] val_q [CHANNELS];
  logic [AGE_W-1:0]  age_q [CHANNELS];

  entry_t cur, kept, fresh;
  logic   removed, placed;

  always_comb begin
    cur.value   = val_q[idx_i];
    cur.age     = age_q[idx_i];
    fresh.value = time_i;
    fresh.age   = new_age_i;

    // removal: pull from the right once the oldest entry has been passed
    removed = link_i.removed | (cur.age == oldest_i);
    kept    = (!LAST && removed) ? right_i : cur;

    // insertion: first slot holding a larger time, last slot otherwise
    placed = link_i.placed | LAST | (kept.value > time_i);

    if (!placed) begin
      next_o = kept;
    end else if (!link_i.placed) begin
      next_o = fresh;
    end else begin
      next_o = link_i.kept;
    end
  end

  assign entry_o        = cur;
  assign link_o.removed = removed;
  assign link_o.placed  = placed;
  assign link_o.kept    = kept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        val_q[c] <= RESET_TIME;
        age_q[c] <= RESET_AGE;
      end
    end else if (we_i) begin
      val_q[idx_i] <= next_o.value;
      age_q[idx_i] <= next_o.age;
    end
  end

endmodule

// ===== hw/rtl/smef_dist.sv =====
module smef_dist (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [smef_pkg::TIME_W-1:0]   median_i,
  output logic                          neg_o,
  output logic [smef_pkg::PROD_W-1:0]   prod_o
);
  import smef_pkg::*;

  logic signed [TIME_W:0] diff;
  logic [TIME_W-1:0]      mag;
  logic [MAG_W-1:0]       scaled;

  // sign-magnitude so the quotient truncates toward zero
  always_comb begin
    diff   = $signed({1'b0, median_i} - TIME_OFFSET);
    mag    = diff[TIME_W] ? TIME_W'(-diff) : diff[TIME_W-1:0];
    scaled = {mag, 4'b0000};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o  <= diff[TIME_W];
      prod_o <= PROD_W'(scaled) * PROD_W'(DIST_RECIP);
    end
  end

endmodule

// ===== hw/rtl/sliding_median_echo_filter_top.sv =====
// An accepted item passes the update and multiply states, then the finish state
// loads its result into the output register; input ready only while no item is in work.
// The finished result sits in an output register, so the next item is taken
// while it waits; the item after that waits for the output register.
// Reset: all windows load time 29500 with ages 0..WINDOW-1 at once, no sweep.
module sliding_median_echo_filter_top #(
  parameter int unsigned CHANNELS = smef_pkg::NUM_CHANNELS,
  parameter int unsigned WINDOW   = smef_pkg::WINDOW_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smef_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smef_pkg::out_item_t out_item_o
);
  import smef_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MID   = WINDOW / 2;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_UPD  = 2'd1;  // cell row updates the window
  localparam logic [1:0] ST_MUL  = 2'd2;  // median scaled by reciprocal
  localparam logic [1:0] ST_FIN  = 2'd3;  // load output register

  logic [1:0] state_q, state_d;

  // item being worked on
  logic [CH_W-1:0]   ch_q;
  logic [TIME_W-1:0] time_q;
  logic              oor_q;     // channel at or beyond CHANNELS
  logic [TIME_W-1:0] median_q;

  logic              out_valid_q;
  out_item_t         out_item_q;

  // per-channel age of the entry due for removal
  logic [AGE_W-1:0]  oldest_q [CHANNELS];

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              upd;
  logic [AGE_W-1:0]  oldest;
  logic [AGE_W-1:0]  new_age;

  link_t  link  [WINDOW+1];
  entry_t ent   [WINDOW+1];
  entry_t nxt   [WINDOW];

  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [DIST_W-1:0] dist_val;
  logic              fin_go;

  assign idx      = IDX_W'(ch_q);
  assign in_range = (32'(ch_q) < CHANNELS);
  assign upd      = (state_q == ST_UPD) && in_range;
  assign oldest   = oldest_q[idx];
  // oldest advances by one; the new entry becomes the youngest
  assign new_age  = AGE_W'(oldest + AGE_W'(WINDOW));

  assign link[0]      = '0;
  assign ent[WINDOW]  = '0;

  // Cell row: one column of the window per cell, all channels per column.
  // Removal and insertion ripple left to right through the link chain; each
  // cell also sees its right neighbor's entry to close the removal gap.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    smef_cell #(
      .CHANNELS  (CHANNELS),
      .IDX_W     (IDX_W),
      .RESET_AGE (AGE_W'(i)),
      .LAST      (i == WINDOW - 1)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .we_i      (upd),
      .idx_i     (idx),
      .time_i    (time_q),
      .oldest_i  (oldest),
      .new_age_i (new_age),
      .link_i    (link[i]),
      .right_i   (ent[i+1]),
      .link_o    (link[i+1]),
      .entry_o   (ent[i]),
      .next_o    (nxt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        oldest_q[c] <= '0;
      end
    end else if (upd) begin
      oldest_q[idx] <= AGE_W'(oldest + 1'b1);
    end
  end

  // Distance: (t - 500) * 16 / 58 via registered reciprocal multiply.
  smef_dist u_dist (
    .clk_i    (clk_i),
    .en_i     (state_q == ST_MUL),
    .median_i (median_q),
    .neg_o    (neg),
    .prod_o   (prod)
  );

  assign quot     = prod[DIST_SHIFT +: QUOT_W];
  assign dist_val = oor_q ? '0 : (neg ? DIST_W'(-{1'b0, quot}) : DIST_W'(quot));
  assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPD;
      end
      ST_UPD:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= in_item_i.channel;
      time_q <= in_item_i.echo_time;
    end
    if (state_q == ST_UPD) begin
      oor_q    <= !in_range;
      median_q <= nxt[MID].value;
    end
    if (fin_go) begin
      out_item_q.channel_out <= ch_q;
      out_item_q.distance    <= $signed(dist_val);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== test/sliding_median_echo_filter_top_tb.sv =====
`timescale 1ns / 100ps

module sliding_median_echo_filter_top_tb;
  import smef_pkg::*;

  // Distance scaling: (t - 500) * 16 / 58, truncated toward zero.
  localparam int OFFSET_TICKS    = 500;
  localparam int TICKS_PER_CM    = 58;
  localparam int SUBCM_STEPS     = 16;

  localparam int N_DIRECTED      = 24;
  localparam int N_RANDOM        = 530;
  localparam int N_QUIET         = 60;   // tail of the random part runs without idling
  localparam int HOLD_AFTER      = 120;  // items sent before the long output hold-off
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sliding_median_echo_filter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the per-channel sorted windows. Each entry carries a 4-bit age;
  // every echo on a used channel retires the entry whose age matches retire_age,
  // then inserts the new time after all entries <= it.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] sorted_time [NUM_CHANNELS][WINDOW_LEN];
  logic [AGE_W-1:0]  entry_age   [NUM_CHANNELS][WINDOW_LEN];
  logic [AGE_W-1:0]  retire_age  [NUM_CHANNELS];

  out_item_t         pending_reports [$];
  logic [TIME_W-1:0] last_time [8];   // per channel, used to force repeated times

  int          items_sent          = 0;
  int          unused_channel_hits = 0;
  int          results_checked     = 0;
  int          mismatches          = 0;
  int          backpressure_cycles = 0;
  int unsigned cycle_count         = 0;
  bit          quiet               = 1'b0;
  bit          hold_active         = 1'b0;
  bit          hold_done           = 1'b0;

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        sorted_time[c][i] = RESET_TIME;
        entry_age[c][i]   = AGE_W'(i);
      end
      retire_age[c] = '0;
    end
    for (int c = 0; c < 8; c++) last_time[c] = RESET_TIME;
  end

  // Updates the shadow window and returns the report the block must produce.
  function automatic out_item_t median_report(in_item_t it);
    out_item_t        rep;
    int               c;
    int               slot;
    int               pos;
    int               dist_calc;
    logic [AGE_W-1:0] fresh_age;
    rep.channel_out = it.channel;
    rep.distance    = '0;
    if (int'(it.channel) >= NUM_CHANNELS) return rep;
    c = it.channel;

    // Oldest entry; the last slot if no age matches.
    slot = WINDOW_LEN - 1;
    for (int i = WINDOW_LEN - 1; i >= 0; i--)
      if (entry_age[c][i] == retire_age[c]) slot = i;
    for (int i = slot; i < WINDOW_LEN - 1; i++) begin
      sorted_time[c][i] = sorted_time[c][i+1];
      entry_age[c][i]   = entry_age[c][i+1];
    end

    retire_age[c] = retire_age[c] + 1'b1;
    fresh_age     = retire_age[c] + AGE_W'(WINDOW_LEN - 1);

    // Ties go behind equal entries.
    pos = 0;
    while (pos < WINDOW_LEN - 1 && sorted_time[c][pos] <= it.echo_time) pos++;
    for (int i = WINDOW_LEN - 1; i > pos; i--) begin
      sorted_time[c][i] = sorted_time[c][i-1];
      entry_age[c][i]   = entry_age[c][i-1];
    end
    sorted_time[c][pos] = it.echo_time;
    entry_age[c][pos]   = fresh_age;

    // Signed int division truncates toward zero, as required just below 500.
    dist_calc = ((int'(sorted_time[c][WINDOW_LEN/2]) - OFFSET_TICKS) * SUBCM_STEPS)
                / TICKS_PER_CM;
    rep.distance = dist_calc[DIST_W-1:0];
    return rep;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Valid rises at a clock edge and holds until the item is taken;
  // consecutive items keep valid high with no dip.
  // ---------------------------------------------------------------------------
  task automatic offer_echo(in_item_t it, bit pinned, logic signed [DIST_W-1:0] pinned_dist);
    out_item_t rep;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    rep = median_report(it);
    if (pinned) rep.distance = pinned_dist;
    pending_reports.push_back(rep);
    items_sent++;
    if (int'(it.channel) >= NUM_CHANNELS) unused_channel_hits++;
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 12);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic in_item_t random_echo();
    in_item_t it;
    if ($urandom_range(0, 9) == 0)
      it.channel = CH_W'($urandom_range(NUM_CHANNELS, 7));
    else
      it.channel = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    case ($urandom_range(0, 11))
      0, 1, 2: it.echo_time = TIME_W'($urandom);
      3, 4:    it.echo_time = TIME_W'(29490 + $urandom_range(0, 20));   // ties near reset fill
      5:       it.echo_time = TIME_W'(480 + $urandom_range(0, 40));     // around zero distance
      6: begin
        if ($urandom_range(0, 1) != 0)
          it.echo_time = 16'hFFFF - TIME_W'($urandom_range(0, 1));
        else
          it.echo_time = TIME_W'($urandom_range(0, 1));
      end
      7, 8:    it.echo_time = last_time[it.channel];                    // exact repeat
      default: it.echo_time = TIME_W'($urandom_range(600, 23700));      // realistic range
    endcase
    last_time[it.channel] = it.echo_time;
    return it;
  endfunction

  // Directed rows: channel, echo time, pinned flag, pinned distance.
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic [TIME_W-1:0]        echo_time;
    logic                     pinned;
    logic signed [DIST_W-1:0] pin_dist;
  } echo_row_t;

  echo_row_t directed_rows [N_DIRECTED] = '{
    '{3'd0, 16'd29500, 1'b1, 16'sd8000},   // reset fill reports 500 cm
    '{3'd1, 16'd0,     1'b1, 16'sd8000},   // smallest time, median unchanged
    '{3'd2, 16'd65535, 1'b1, 16'sd8000},   // largest time, median unchanged
    '{3'd6, 16'd1234,  1'b1, 16'sd0},      // unused channel: zero, no update
    '{3'd7, 16'd65535, 1'b1, 16'sd0},
    // six zeros pull the median of channel 3 down to the minimum distance
    '{3'd3, 16'd0, 1'b1, 16'sd8000},
    '{3'd3, 16'd0, 1'b1, 16'sd8000},
    '{3'd3, 16'd0, 1'b1, 16'sd8000},
    '{3'd3, 16'd0, 1'b1, 16'sd8000},
    '{3'd3, 16'd0, 1'b1, 16'sd8000},
    '{3'd3, 16'd0, 1'b1, -16'sd137},
    // six full-scale times push channel 4 to the maximum distance
    '{3'd4, 16'd65535, 1'b1, 16'sd8000},
    '{3'd4, 16'd65535, 1'b1, 16'sd8000},
    '{3'd4, 16'd65535, 1'b1, 16'sd8000},
    '{3'd4, 16'd65535, 1'b1, 16'sd8000},
    '{3'd4, 16'd65535, 1'b1, 16'sd8000},
    '{3'd4, 16'd65535, 1'b1, 16'sd17940},
    // ties and near-zero distances, checked by the shadow window
    '{3'd0, 16'd29500, 1'b0, 16'sd0},
    '{3'd0, 16'd29499, 1'b0, 16'sd0},
    '{3'd0, 16'd29501, 1'b0, 16'sd0},
    '{3'd0, 16'd500,   1'b0, 16'sd0},
    '{3'd5, 16'd499,   1'b0, 16'sd0},
    '{3'd5, 16'd501,   1'b0, 16'sd0},
    '{3'd3, 16'd0,     1'b0, 16'sd0}     // a seventh zero lands among equal entries
  };

  initial begin
    in_item_t it;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) begin
      it.channel   = directed_rows[r].channel;
      it.echo_time = directed_rows[r].echo_time;
      offer_echo(it, directed_rows[r].pinned, directed_rows[r].pin_dist);
      if (r % 3 == 2) sender_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= N_RANDOM - N_QUIET) quiet = 1'b1;
      if (!quiet && !hold_active && $urandom_range(0, 2) == 0) sender_gap();
      offer_echo(random_echo(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_reports.size()));

    $display("ran %0d echoes (%0d on unused channels), %0d reports checked, %0d mismatches",
             items_sent, unused_channel_hits, results_checked, mismatches);
    $display("input held back on %0d cycles, incl. one %0d-cycle output hold-off",
             backpressure_cycles, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("sliding_median_echo_filter_top: match");
    end else begin
      $display("sliding_median_echo_filter_top: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random ready bursts, one long hold-off so the block fills
  // and stalls its input, and steady ready in the quiet tail.
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge clk_i);
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest pending report.
  // ---------------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_ready) backpressure_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("report for channel %0d with nothing pending",
                               out_item.channel_out));
      end else begin
        want = pending_reports.pop_front();
        if (out_item.channel_out !== want.channel_out)
          log_mismatch($sformatf("report %0d: channel_out expected %0d, got %0d",
                                 results_checked, want.channel_out, out_item.channel_out));
        if (out_item.distance !== want.distance)
          log_mismatch($sformatf("report %0d (ch %0d): distance expected %0d, got %0d",
                                 results_checked, want.channel_out, want.distance,
                                 out_item.distance));
      end
      results_checked++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending",
               cycle_count, pending_reports.size());
      $display("sliding_median_echo_filter_top: mismatch");
      $finish;
    end
  end

endmodule
